// ===== hw/rtl/gcrd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcrd_pkg
// Shared types, sizes and the 5-to-4 GCR code table for the sector decoder.
// ----------------------------------------------------------------------------
package gcrd_pkg;

	localparam int BLOCK_BYTES = 256;
	localparam int GROUPS      = BLOCK_BYTES / 4;
	localparam int GRP_W       = $clog2(GROUPS + 2);

	localparam logic [7:0] MARKER   = 8'h07;
	localparam logic [7:0] BAD_CODE = 8'hFF;

	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_BAD_MARKER = 2'd1;
	localparam logic [1:0] STATUS_BAD_CSUM   = 2'd2;

	localparam logic [2:0] PHASE_LAST = 3'd4;

	typedef logic [GRP_W-1:0] grp_t;

	localparam grp_t GROUP_LAST = grp_t'(GROUPS);

	typedef struct packed {
		logic [7:0] gcr_byte;
		logic       block_start;
	} gcrd_in_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       data_valid;
		logic [1:0] block_status;
		logic       block_done;
	} gcrd_out_t;

	typedef struct packed {
		logic [7:0] bits;      // leftover GCR bits, right aligned, zero above
		logic [2:0] phase;     // byte position within the five byte group
		grp_t       group;     // group index within the block
		logic [7:0] csum;      // running XOR of the payload bytes
		logic       discard;   // ignore input until the next block start
	} gcrd_state_t;

	function automatic logic [7:0] gcr_code(input logic [4:0] code);
		logic [7:0] v;
		unique case (code)
			5'h09:   v = 8'd8;
			5'h0A:   v = 8'd0;
			5'h0B:   v = 8'd1;
			5'h0D:   v = 8'd12;
			5'h0E:   v = 8'd4;
			5'h0F:   v = 8'd5;
			5'h12:   v = 8'd2;
			5'h13:   v = 8'd3;
			5'h15:   v = 8'd15;
			5'h16:   v = 8'd6;
			5'h17:   v = 8'd7;
			5'h19:   v = 8'd9;
			5'h1A:   v = 8'd10;
			5'h1B:   v = 8'd11;
			5'h1D:   v = 8'd13;
			5'h1E:   v = 8'd14;
			default: v = BAD_CODE;
		endcase
		return v;
	endfunction

	// A bad high code leaves nibble F after the shift; a bad low code forces 0xFF.
	function automatic logic [7:0] gcr_decode_pair(input logic [9:0] pair);
		logic [7:0] hi;
		logic [7:0] lo;
		hi = gcr_code(pair[9:5]);
		lo = gcr_code(pair[4:0]);
		return {hi[3:0], 4'h0} | lo;
	endfunction

endpackage

// ===== hw/rtl/gcr_sector_block_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcr_sector_block_decoder_top
// GCR 5-to-4 sector data block decoder with marker and checksum check.
// ----------------------------------------------------------------------------
// The block takes one GCR byte per cycle while no result waits untaken in
// the output register. A byte passes an input register, then the decode and
// block state logic, and its result, if any, is registered in the output
// register. Each payload byte is delivered as soon as its ten code bits
// are in; the word that ends a block carries block_done and the status. Bytes
// that follow a finished or rejected block produce no word until block_start.
// ----------------------------------------------------------------------------
module gcr_sector_block_decoder_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  gcrd_pkg::gcrd_in_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output gcrd_pkg::gcrd_out_t result
);
	import gcrd_pkg::*;

	logic        item_valid_s1;
	gcrd_in_t    item_s1;
	gcrd_state_t state_q;
	gcrd_state_t state_next;
	gcrd_out_t   step_res;
	logic        step_has_result;
	logic        result_valid_q;
	gcrd_out_t   result_q;
	logic        advance;

	assign advance    = item_valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !item_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item_ready) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	gcrd_step u_step (
		.cur        (state_q),
		.item       (item_s1),
		.nxt        (state_next),
		.res        (step_res),
		.has_result (step_has_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= step_has_result;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= step_res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// A word is either a payload byte or a block status, never both.
	a_word_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (result_q.data_valid != result_q.block_done))
		else $error("result word is neither or both payload and status");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase <= PHASE_LAST)
		else $error("group phase out of range");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid_s1 && result_valid_q && !result_ready) |-> !item_ready)
		else $error("input accepted while the pipeline is stalled");

	// After a rejected marker the rest of the block must be dropped.
	a_marker_discard: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step_has_result && step_res.block_done &&
		 step_res.block_status == STATUS_BAD_MARKER) |=> state_q.discard)
		else $error("bad marker did not start discarding");

endmodule

// ===== hw/rtl/gcrd_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcrd_step
// Next-state and result logic for one GCR byte of a sector block.
// ----------------------------------------------------------------------------
module gcrd_step (
	input  gcrd_pkg::gcrd_state_t cur,
	input  gcrd_pkg::gcrd_in_t    item,
	output gcrd_pkg::gcrd_state_t nxt,
	output gcrd_pkg::gcrd_out_t   res,
	output logic                  has_result
);
	import gcrd_pkg::*;

	gcrd_state_t st;
	logic [9:0]  pair;
	logic [7:0]  bits_next;
	logic [7:0]  dec;

	always_comb begin
		if (item.block_start) begin
			st = '0;
		end else begin
			st = cur;
		end
	end

	// Each non-first byte of a group completes one ten bit code pair.
	always_comb begin
		unique case (st.phase)
			3'd1: begin
				pair      = {st.bits, item.gcr_byte[7:6]};
				bits_next = {2'b00, item.gcr_byte[5:0]};
			end
			3'd2: begin
				pair      = {st.bits[5:0], item.gcr_byte[7:4]};
				bits_next = {4'h0, item.gcr_byte[3:0]};
			end
			3'd3: begin
				pair      = {st.bits[3:0], item.gcr_byte[7:2]};
				bits_next = {6'b000000, item.gcr_byte[1:0]};
			end
			3'd4: begin
				pair      = {st.bits[1:0], item.gcr_byte};
				bits_next = 8'h00;
			end
			default: begin
				pair      = 10'h000;
				bits_next = item.gcr_byte;
			end
		endcase
	end

	assign dec = gcr_decode_pair(pair);

	always_comb begin
		nxt        = st;
		res        = '0;
		has_result = 1'b0;
		if (!st.discard) begin
			nxt.bits = bits_next;
			if (st.phase == PHASE_LAST) begin
				nxt.phase = 3'd0;
				nxt.group = st.group + grp_t'(1);
				if (st.group == GROUP_LAST) begin
					nxt.discard = 1'b1;
				end
			end else begin
				nxt.phase = st.phase + 3'd1;
			end
			if (st.phase != 3'd0) begin
				if (st.group == '0 && st.phase == 3'd1) begin
					if (dec != MARKER) begin
						res.block_status = STATUS_BAD_MARKER;
						res.block_done   = 1'b1;
						has_result       = 1'b1;
						nxt.discard      = 1'b1;
					end
				end else if (st.group < GROUP_LAST ||
						(st.group == GROUP_LAST && st.phase == 3'd1)) begin
					nxt.csum       = st.csum ^ dec;
					res.data_byte  = dec;
					res.data_valid = 1'b1;
					has_result     = 1'b1;
				end else if (st.group == GROUP_LAST && st.phase == 3'd2) begin
					res.block_status = (dec != st.csum) ? STATUS_BAD_CSUM : STATUS_OK;
					res.block_done   = 1'b1;
					has_result       = 1'b1;
				end
			end
		end
	end

endmodule

// ===== tb/gcr_sector_block_decoder_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcr_sector_block_decoder_top_tb
// Drives GCR coded blocks (well-formed, truncated, corrupted, bad marker and
// bad checksum) plus noise into the sector decoder. It predicts every output
// word with a local decoder model and checks each word in order of arrival.
// Random idling on both sides and one long output stall are applied.
// ----------------------------------------------------------------------------
module gcr_sector_block_decoder_top_tb;
	import gcrd_pkg::*;

	localparam int BLOCK_IN_BYTES = 5 * (GROUPS + 1);
	localparam int ITEM_TARGET    = 1350;
	localparam int CYCLE_LIMIT    = 200000;
	localparam int HOLD_CYCLES    = 400;

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b0;
	logic      item_valid   = 1'b0;
	logic      item_ready;
	gcrd_in_t  item         = '0;
	logic      result_valid;
	logic      result_ready = 1'b0;
	gcrd_out_t result;

	gcr_sector_block_decoder_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	always #5 clk = ~clk;

	// 5-bit GCR code to nibble; 8'hFF marks an illegal code.
	logic [7:0] gcr_nibble [32] = '{
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'hFF, 8'd8,  8'd0,  8'd1,  8'hFF, 8'd12, 8'd4,  8'd5,
		8'hFF, 8'hFF, 8'd2,  8'd3,  8'hFF, 8'd15, 8'd6,  8'd7,
		8'hFF, 8'd9,  8'd10, 8'd11, 8'hFF, 8'd13, 8'd14, 8'hFF
	};
	logic [4:0] nibble_code [16];

	gcrd_in_t  pending_bytes[$];
	gcrd_out_t predicted_words[$];

	// Decoder state as the block should hold it.
	logic [15:0] gcr_bits  = '0;
	int          byte_pos  = 0;
	logic [7:0]  sum_acc   = '0;
	logic [7:0]  sum_ref   = '0;
	bit          skipping  = 1'b0;

	int sent_cnt    = 0;
	int total_items = 0;
	int fail_cnt    = 0;
	int cycle_cnt   = 0;
	int hold_left   = 0;
	bit hold_done   = 1'b0;

	function automatic logic [7:0] pair_value(input logic [9:0] pair);
		logic [7:0] hi;
		logic [7:0] lo;
		hi = gcr_nibble[pair[9:5]];
		lo = gcr_nibble[pair[4:0]];
		return {hi[3:0], 4'h0} | lo;
	endfunction

	function automatic void decode_gcr_byte(input gcrd_in_t w);
		int          phase;
		int          grp;
		int          keep;
		int          idx;
		logic [15:0] acc;
		logic [15:0] shifted;
		logic [7:0]  dec;
		gcrd_out_t   r;
		r = '0;
		if (w.block_start) begin
			gcr_bits = '0;
			byte_pos = 0;
			sum_acc  = '0;
			sum_ref  = '0;
			skipping = 1'b0;
		end
		if (skipping || byte_pos >= BLOCK_IN_BYTES) begin
			skipping = 1'b1;
			return;
		end
		phase = byte_pos % 5;
		grp   = byte_pos / 5;
		if (phase == 0) begin
			gcr_bits = {8'h00, w.gcr_byte};
		end else begin
			keep     = 8 - 2 * phase;
			acc      = {gcr_bits[7:0], w.gcr_byte};
			shifted  = acc >> keep;
			dec      = pair_value(shifted[9:0]);
			gcr_bits = acc & ((16'd1 << keep) - 16'd1);
			idx      = 4 * grp + phase - 1;
			if (idx == 0) begin
				if (dec != MARKER) begin
					r.block_status = STATUS_BAD_MARKER;
					r.block_done   = 1'b1;
					predicted_words.push_back(r);
					skipping = 1'b1;
				end
			end else if (idx <= 4 * GROUPS) begin
				sum_acc      ^= dec;
				r.data_byte  = dec;
				r.data_valid = 1'b1;
				predicted_words.push_back(r);
			end else if (idx == 4 * GROUPS + 1) begin
				sum_ref        = dec;
				r.block_status = (sum_ref != sum_acc) ? STATUS_BAD_CSUM : STATUS_OK;
				r.block_done   = 1'b1;
				predicted_words.push_back(r);
			end
		end
		byte_pos++;
		if (byte_pos >= BLOCK_IN_BYTES)
			skipping = 1'b1;
	endfunction

	function automatic logic [39:0] encode_group(input logic [31:0] four);
		logic [39:0] bits;
		logic [3:0]  nib;
		for (int i = 0; i < 8; i++) begin
			nib = four[31 - 4 * i -: 4];
			bits[39 - 5 * i -: 5] = nibble_code[nib];
		end
		return bits;
	endfunction

	task automatic queue_byte(input logic [7:0] b, input logic start);
		gcrd_in_t w;
		w.gcr_byte    = b;
		w.block_start = start;
		pending_bytes.push_back(w);
	endtask

	task automatic queue_bits(input logic [39:0] bits, input logic start, input int n);
		for (int k = 0; k < n; k++)
			queue_byte(bits[39 - 8 * k -: 8], start && (k == 0));
	endtask

	// Builds a whole coded block and queues its first n_bytes bytes.
	task automatic queue_block(input logic [7:0] marker, input int n_bytes,
			input bit bad_sum, input int n_corrupt);
		logic [7:0]  plain [4 * (GROUPS + 1)];
		logic [7:0]  coded [BLOCK_IN_BYTES];
		logic [7:0]  sum;
		logic [39:0] bits;
		sum      = '0;
		plain[0] = marker;
		for (int i = 1; i <= 4 * GROUPS; i++) begin
			plain[i] = 8'($urandom);
			sum ^= plain[i];
		end
		plain[4 * GROUPS + 1] = bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum;
		plain[4 * GROUPS + 2] = 8'($urandom);
		plain[4 * GROUPS + 3] = 8'($urandom);
		for (int g = 0; g <= GROUPS; g++) begin
			bits = encode_group({plain[4 * g], plain[4 * g + 1],
				plain[4 * g + 2], plain[4 * g + 3]});
			for (int k = 0; k < 5; k++)
				coded[5 * g + k] = bits[39 - 8 * k -: 8];
		end
		repeat (n_corrupt)
			coded[$urandom_range(0, BLOCK_IN_BYTES - 1)] = 8'($urandom);
		for (int i = 0; i < n_bytes; i++)
			queue_byte(coded[i], i == 0);
	endtask

	function automatic int idle_pct(input bit rx_side);
		int stage;
		stage = (total_items == 0) ? 0 : (sent_cnt * 3) / total_items;
		case (stage)
			0:       return rx_side ? 82 : 24;
			1:       return rx_side ? 24 : 82;
			default: return 0;
		endcase
	endfunction

	always @(posedge clk)
		cycle_cnt <= cycle_cnt + 1;

	// Driver: a new word is offered only once the current one is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item       <= '0;
		end else begin
			if (item_valid && item_ready) begin
				decode_gcr_byte(item);
				sent_cnt <= sent_cnt + 1;
			end
			if (!item_valid || item_ready) begin
				if (pending_bytes.size() != 0 &&
						$urandom_range(0, 99) >= idle_pct(1'b0)) begin
					item       <= pending_bytes.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// One long output stall late in the run so the decoder backs up.
	always @(posedge clk) begin
		if (!hold_done && total_items != 0 && sent_cnt >= (total_items * 4) / 5) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (predicted_words.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("%0t: unexpected word data %02h/%0b status %0d/%0b",
							$realtime, result.data_byte, result.data_valid,
							result.block_status, result.block_done);
				end else begin
					automatic gcrd_out_t exp_w = predicted_words.pop_front();
					if (result.data_byte !== exp_w.data_byte
							|| result.data_valid !== exp_w.data_valid
							|| result.block_status !== exp_w.block_status
							|| result.block_done !== exp_w.block_done) begin
						fail_cnt++;
						if (fail_cnt <= 10)
							$display("%0t: expected %02h/%0b %0d/%0b, got %02h/%0b %0d/%0b",
								$realtime, exp_w.data_byte, exp_w.data_valid,
								exp_w.block_status, exp_w.block_done,
								result.data_byte, result.data_valid,
								result.block_status, result.block_done);
					end
				end
			end
			result_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= idle_pct(1'b1));
		end
	end

	initial begin
		int n_blocks;
		int kind;
		logic [7:0] m;
		for (int c = 0; c < 32; c++)
			if (gcr_nibble[c] != 8'hFF)
				nibble_code[gcr_nibble[c][3:0]] = 5'(c);

		// First word after reset has no start flag but still opens a block.
		// Its payload holds an illegal high code, an illegal low code and zero.
		queue_bits({5'h0A, 5'h17, 5'h00, 5'h0A, 5'h0A, 5'h1F, 5'h0A, 5'h0A}, 1'b0, 5);
		// Bad markers, then bytes that must be ignored until the next start.
		queue_byte(8'hFF, 1'b1);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h55, 1'b0);
		queue_byte(8'h00, 1'b1);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b0);
		// A block cut short by a restart in the middle of a group.
		queue_bits(encode_group({MARKER, 8'hA5, 8'h5A, 8'hFF}), 1'b1, 3);
		queue_bits(encode_group({MARKER, 8'h00, 8'hFF, 8'h3C}), 1'b1, 5);

		n_blocks = 0;
		while (pending_bytes.size() < ITEM_TARGET) begin
			kind = (n_blocks < 2) ? 0 : $urandom_range(0, 9);
			if (kind <= 4) begin
				queue_block(MARKER, BLOCK_IN_BYTES,
					(n_blocks == 1) || (n_blocks > 1 && $urandom_range(0, 3) == 0),
					(n_blocks > 1 && $urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
				repeat ($urandom_range(0, 4))
					queue_byte(8'($urandom), 1'b0);
			end else if (kind <= 6) begin
				queue_block(MARKER, $urandom_range(1, BLOCK_IN_BYTES - 1), 1'b0, 0);
			end else if (kind == 7) begin
				m = 8'($urandom);
				if (m == MARKER)
					m = ~m;
				queue_block(m, $urandom_range(2, 12), 1'b0, 0);
			end else begin
				repeat ($urandom_range(5, 20))
					queue_byte(8'($urandom), $urandom_range(0, 7) == 0);
			end
			n_blocks++;
		end
		// The last block may end early; the predictor follows whatever is sent.
		while (pending_bytes.size() > ITEM_TARGET)
			void'(pending_bytes.pop_back());
		total_items = pending_bytes.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while ((pending_bytes.size() != 0 || item_valid) && cycle_cnt < CYCLE_LIMIT)
			@(posedge clk);
		while (predicted_words.size() != 0 && cycle_cnt < CYCLE_LIMIT)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			fail_cnt++;
		end
		if (predicted_words.size() != 0)
			fail_cnt++;
		if (fail_cnt == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== gcr_sector_block_decoder_top.f =====
hw/rtl/gcrd_pkg.sv
hw/rtl/gcrd_step.sv
hw/rtl/gcr_sector_block_decoder_top.sv
tb/gcr_sector_block_decoder_top_tb.sv
